@@ design/u16u8_pkg.sv @@
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8 converter.
`default_nettype none

package u16u8_pkg;

   localparam int CAP_W       = 11;
   localparam int CP_W        = 21;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd128;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_W-1:0] SUPP_BASE   = 21'h010000;

   // UTF-8 form of U+FFFD
   localparam logic [2:0][7:0] REPL_BYTES = {8'hBD, 8'hBF, 8'hEF};
   localparam logic [2:0]      REPL_LEN   = 3'd3;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_string;
   } rsp_data_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_char_type;

   // One queued job: optional U+FFFD, optional character, optional terminator
   typedef struct packed {
      logic          repl_en;
      utf8_char_type chr;
      logic          term;
   } job_type;

   function automatic utf8_char_type utf8_encode(input logic [CP_W-1:0] cp);
      utf8_char_type r;
      r = '0;
      if (cp <= 21'h00007F) begin
         r.bytes[0] = cp[7:0];
         r.len      = 3'd1;
      end else if (cp <= 21'h0007FF) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.len      = 3'd2;
      end else if (cp <= 21'h00FFFF) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.len      = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.len      = 3'd4;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/u16u8_front.sv @@
// Front end: takes code units, pairs surrogates, checks capacity, builds byte jobs.
`default_nettype none

module u16u8_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          accept,
   input  u16u8_pkg::req_data_type      req_data,
   input  wire                          csr_wr_en,
   input  wire [u16u8_pkg::CAP_W-1:0]   csr_wr_data,
   output logic                         push,
   output u16u8_pkg::job_type           push_job
);
   import u16u8_pkg::*;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [9:0]       held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic [CAP_W-1:0] written_ff, written_in;
   logic             stopped_ff, stopped_in;

   logic [15:0]      u;
   logic             is_high, is_low;
   logic [CP_W-1:0]  pair_cp, char_cp;
   logic             try_char;
   logic [CAP_W:0]   written_mid;
   logic             stopped_mid;
   utf8_char_type    enc;
   logic [CAP_W:0]   sum_repl, sum_char;

   assign u       = req_data.code_unit;
   assign is_high = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
   assign is_low  = (u >= LOW_FIRST) && (u <= LOW_LAST);
   assign pair_cp = SUPP_BASE + {1'b0, held_ff, u[9:0]};

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      written_in    = written_ff;
      stopped_in    = stopped_ff;
      push_job      = '0;
      try_char      = 1'b0;
      char_cp       = {5'd0, u};
      written_mid   = {1'b0, written_ff};
      stopped_mid   = stopped_ff;
      sum_repl      = {1'b0, written_ff} + {{(CAP_W-2){1'b0}}, REPL_LEN};

      if (accept && !stopped_ff) begin
         if (held_valid_ff && is_low) begin
            held_valid_in = 1'b0;
            try_char      = 1'b1;
            char_cp       = pair_cp;
         end else begin
            if (held_valid_ff) begin
               held_valid_in = 1'b0;
               if (sum_repl < {1'b0, capacity_ff}) begin
                  push_job.repl_en = 1'b1;
                  written_mid      = sum_repl;
               end else begin
                  stopped_mid = 1'b1;
               end
            end
            if (!stopped_mid) begin
               if (u == 16'd0) begin
                  stopped_mid = 1'b1;
               end else if (is_high) begin
                  if (req_data.last_unit) begin
                     try_char = 1'b1;
                     char_cp  = REPLACEMENT;
                  end else begin
                     held_in       = u[9:0];
                     held_valid_in = 1'b1;
                  end
               end else if (is_low) begin
                  try_char = 1'b1;
                  char_cp  = REPLACEMENT;
               end else begin
                  try_char = 1'b1;
               end
            end
         end
      end

      enc      = utf8_encode(char_cp);
      sum_char = written_mid + {{(CAP_W-2){1'b0}}, enc.len};
      if (try_char) begin
         if (sum_char < {1'b0, capacity_ff}) begin
            push_job.chr = enc;
            written_mid  = sum_char;
         end else begin
            stopped_mid   = 1'b1;
            held_valid_in = 1'b0;
         end
      end

      if (accept) begin
         written_in = written_mid[CAP_W-1:0];
         stopped_in = stopped_mid;
         if (req_data.last_unit) begin
            push_job.term = 1'b1;
            held_in       = '0;
            held_valid_in = 1'b0;
            written_in    = '0;
            stopped_in    = 1'b0;
         end
      end

      push = accept && (push_job.repl_en || (push_job.chr.len != 3'd0) || push_job.term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CAP_RESET;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         written_ff    <= '0;
         stopped_ff    <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         written_ff    <= written_in;
         stopped_ff    <= stopped_in;
      end
   end

`ifndef SYNTHESIS
   a_stop_drops_held: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !held_valid_ff)
      else $error("high surrogate pending while conversion stopped");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_unit) |=> (written_ff == '0) && !stopped_ff && !held_valid_ff)
      else $error("string state not cleared after last word");
`endif

endmodule

`default_nettype wire

@@ design/u16u8_job_queue.sv @@
// Short FIFO of byte jobs between the front end and the byte sequencer.
`default_nettype none

module u16u8_job_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  u16u8_pkg::job_type     push_job,
   input  wire                    pop,
   output logic                   full,
   output logic                   head_valid,
   output u16u8_pkg::job_type     head_job
);
   import u16u8_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("job pushed into full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

@@ design/u16u8_back.sv @@
// Back end: walks each job byte by byte into the output register.
`default_nettype none

module u16u8_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        head_valid,
   input  u16u8_pkg::job_type         head_job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output u16u8_pkg::rsp_data_type    rsp_data
);
   import u16u8_pkg::*;

   logic [2:0]    idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   logic [3:0]    total;
   logic [2:0]    repl_len, rel;
   logic          out_free, last_byte;
   rsp_data_type  cur;

   assign repl_len  = head_job.repl_en ? REPL_LEN : 3'd0;
   assign total     = {1'b0, repl_len} + {1'b0, head_job.chr.len} + {3'd0, head_job.term};
   assign last_byte = ({1'b0, idx_ff} == total - 4'd1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rel       = idx_ff - repl_len;

   always_comb begin
      cur = '0;
      if (idx_ff < repl_len) begin
         cur.out_byte = REPL_BYTES[idx_ff[1:0]];
      end else if (rel < head_job.chr.len) begin
         cur.out_byte = head_job.chr.bytes[rel[1:0]];
      end else begin
         cur.end_of_string = 1'b1;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      if (out_free) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_data_in = cur;
            if (last_byte) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < total))
      else $error("byte index beyond job length");
`endif

endmodule

`default_nettype wire

@@ design/utf16_to_utf8_stream_converter.sv @@
// The first UTF-8 byte of a word is registered in the job queue and then in the output
// register before it is on rsp.
// Throughput: the output register emits one byte per cycle while rsp_stall is low; a word
// yields 0 to 7 bytes (3 for U+FFFD of an unpaired high, up to 4 for the
// character, 1 for the terminator). Words are accepted every cycle while the queue has room.
// Reset (synchronous): capacity returns to 128, string state clears, queue and output empty.
`default_nettype none

module utf16_to_utf8_stream_converter (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  u16u8_pkg::req_data_type      req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output u16u8_pkg::rsp_data_type      rsp_data,
   input  wire                          csr_wr_en,
   input  wire [u16u8_pkg::CAP_W-1:0]   csr_wr_data
);
   import u16u8_pkg::*;

   logic     accept;
   logic     push, pop, full, head_valid;
   job_type  push_job, head_job;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_job    (push_job)
   );

   u16u8_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
